### design/frr_pkg.sv
// ----------------------------------------------------------------------------
// frr_pkg: shared types and constants of the framed reply receiver
// Payload structs, status codes, controller states and the CRC-32 byte step.
// ----------------------------------------------------------------------------
package frr_pkg;

  localparam logic [31:0] CrcPoly   = 32'hEDB88320;
  localparam logic [31:0] CrcInit   = 32'hFFFFFFFF;
  localparam logic [7:0]  MagicB0   = 8'h46;
  localparam logic [7:0]  MagicB1   = 8'h50;
  localparam logic [7:0]  MagicB2   = 8'h53;
  localparam logic [7:0]  MagicB3   = 8'h48;
  localparam logic [7:0]  FrameVer  = 8'h01;
  localparam logic [5:0]  PayloadMax = 6'd44;
  localparam logic [5:0]  PayloadOff = 6'd20;
  localparam int unsigned HdrBytes   = 24;
  localparam logic [7:0]  StaleReset = 8'd32;

  localparam logic KindData = 1'b0;
  localparam logic KindEnd  = 1'b1;
  localparam logic ReqBegin = 1'b0;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_MAGIC      = 3'd1,
    ST_FRAME_CRC  = 3'd2,
    ST_STALE_LIM  = 3'd3,
    ST_BLOCK_LONG = 3'd4,
    ST_BLOCK_CRC  = 3'd5,
    ST_STALE_LONG = 3'd6,
    ST_RAW_CAP    = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE, PH_RAW, PH_FRAME, PH_BLOCK, PH_SKIP
  } phase_e;

  typedef enum logic [2:0] {
    CS_WAIT, CS_STEP, CS_CHECK, CS_EMIT, CS_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic        req_type;
    logic [31:0] sequence_req;
    logic [23:0] raw_length;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  reply_byte;
    logic        unchecked;
    logic [2:0]  status;
    logic [24:0] reply_length;
    logic        last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic    take;
    logic    begin_req;
    logic    raw_b;
    logic    blk_b;
    logic    skip_b;
    logic    frm_b;
    logic    chk;
    logic    emit;
    logic    fin;
    status_e end_st;
    logic    last;
    logic    load_rem;
    logic    blk_start;
    logic    add_used;
    logic    frame_inc;
    logic    stale_inc;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic accept;
    logic it_begin;
    logic raw_zero;
    logic raw_over;
    logic rem_one;
    logic idx_last;
    logic hdr_bad;
    logic crc_bad;
    logic stale;
    logic flag_blk;
    logic flag_chain;
    logic plen_gt_skip;
    logic plen_zero;
    logic plen_ge_cap;
    logic cap_ok;
    logic n_zero;
    logic frame_lim;
    logic stale_at_max;
    logic blk_crc_ok;
    logic emit_last;
    logic out_free;
  } stat_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = (r >> 1) ^ (r[0] ? CrcPoly : 32'd0);
    end
    return r;
  endfunction

endpackage

### design/frr_ctrl.sv
// ----------------------------------------------------------------------------
// frr_ctrl: reply receiver controller
// Tracks the reply phase and sequences step, frame check, payload emit, end.
// ----------------------------------------------------------------------------
module frr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  frr_pkg::stat_t st_i,
  output frr_pkg::cmd_t  cmd_o
);
  import frr_pkg::*;

  ctrl_state_e cs_q, cs_d;
  phase_e      ph_q, ph_d;
  status_e     end_st_q, end_st_d;
  logic        end_blk_q, end_blk_d;
  logic        end_follow_q, end_follow_d;
  logic        chain_end;

  assign chain_end = !st_i.flag_chain || st_i.frame_lim;

  // next state
  always_comb begin
    cs_d         = cs_q;
    ph_d         = ph_q;
    end_st_d     = end_st_q;
    end_blk_d    = end_blk_q;
    end_follow_d = end_follow_q;
    case (cs_q)
      CS_WAIT: begin
        if (st_i.accept) cs_d = CS_STEP;
      end
      CS_STEP: begin
        if (st_i.it_begin) begin
          end_blk_d = 1'b0;
          if (st_i.raw_zero) begin
            ph_d = PH_FRAME; cs_d = CS_WAIT;
          end else if (st_i.raw_over) begin
            ph_d = PH_IDLE; cs_d = CS_DONE; end_st_d = ST_RAW_CAP;
          end else begin
            ph_d = PH_RAW; cs_d = CS_WAIT;
          end
        end else begin
          case (ph_q)
            PH_RAW, PH_BLOCK: begin
              if (st_i.out_free) begin
                if (st_i.rem_one) begin
                  ph_d = PH_IDLE; cs_d = CS_DONE; end_st_d = ST_OK;
                  end_blk_d = (ph_q == PH_BLOCK);
                end else begin
                  cs_d = CS_WAIT;
                end
              end
            end
            PH_SKIP: begin
              if (st_i.rem_one && st_i.stale_at_max) begin
                ph_d = PH_IDLE; cs_d = CS_DONE; end_st_d = ST_STALE_LIM; end_blk_d = 1'b0;
              end else begin
                if (st_i.rem_one) ph_d = PH_FRAME;
                cs_d = CS_WAIT;
              end
            end
            PH_FRAME: begin
              cs_d = st_i.idx_last ? CS_CHECK : CS_WAIT;
            end
            default: cs_d = CS_WAIT;
          endcase
        end
      end
      CS_CHECK: begin
        end_blk_d = 1'b0;
        cs_d      = CS_DONE;
        ph_d      = PH_IDLE;
        if (st_i.hdr_bad) begin
          end_st_d = ST_MAGIC;
        end else if (st_i.crc_bad) begin
          end_st_d = ST_FRAME_CRC;
        end else if (st_i.stale) begin
          if (st_i.flag_blk && st_i.plen_gt_skip) begin
            end_st_d = ST_STALE_LONG;
          end else if (st_i.flag_blk && !st_i.plen_zero) begin
            ph_d = PH_SKIP; cs_d = CS_WAIT;
          end else if (st_i.stale_at_max) begin
            end_st_d = ST_STALE_LIM;
          end else begin
            ph_d = PH_FRAME; cs_d = CS_WAIT;
          end
        end else if (st_i.flag_blk) begin
          if (st_i.plen_ge_cap) begin
            end_st_d = ST_BLOCK_LONG;
          end else if (st_i.plen_zero) begin
            end_st_d = ST_OK; end_blk_d = 1'b1;
          end else begin
            ph_d = PH_BLOCK; cs_d = CS_WAIT;
          end
        end else begin
          end_st_d     = ST_OK;
          end_follow_d = chain_end;
          if (!chain_end) ph_d = PH_FRAME;
          if (st_i.cap_ok && !st_i.n_zero) cs_d = CS_EMIT;
          else if (!chain_end) cs_d = CS_WAIT;
        end
      end
      CS_EMIT: begin
        if (st_i.out_free && st_i.emit_last) cs_d = end_follow_q ? CS_DONE : CS_WAIT;
      end
      CS_DONE: begin
        if (st_i.out_free) cs_d = CS_WAIT;
      end
      default: cs_d = CS_WAIT;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o        = '0;
    cmd_o.end_st = end_st_q;
    case (cs_q)
      CS_WAIT: cmd_o.take = 1'b1;
      CS_STEP: begin
        if (st_i.it_begin) begin
          cmd_o.begin_req = 1'b1;
        end else begin
          case (ph_q)
            PH_RAW: begin
              cmd_o.raw_b = st_i.out_free;
              cmd_o.last  = !st_i.rem_one;
            end
            PH_BLOCK: begin
              cmd_o.blk_b = st_i.out_free;
              cmd_o.last  = !st_i.rem_one;
            end
            PH_SKIP: begin
              cmd_o.skip_b    = 1'b1;
              cmd_o.stale_inc = st_i.rem_one && !st_i.stale_at_max;
            end
            PH_FRAME: cmd_o.frm_b = 1'b1;
            default: ;
          endcase
        end
      end
      CS_CHECK: begin
        cmd_o.chk = 1'b1;
        if (!st_i.hdr_bad && !st_i.crc_bad) begin
          if (st_i.stale) begin
            if (st_i.flag_blk && !st_i.plen_gt_skip && !st_i.plen_zero) begin
              cmd_o.load_rem = 1'b1;
            end else if (!(st_i.flag_blk && st_i.plen_gt_skip)) begin
              cmd_o.stale_inc = !st_i.stale_at_max;
            end
          end else if (st_i.flag_blk) begin
            if (!st_i.plen_ge_cap) begin
              cmd_o.blk_start = 1'b1;
              cmd_o.load_rem  = 1'b1;
            end
          end else begin
            cmd_o.add_used  = st_i.cap_ok;
            cmd_o.frame_inc = !chain_end;
          end
        end
      end
      CS_EMIT: begin
        cmd_o.emit = st_i.out_free;
        cmd_o.last = st_i.emit_last && !end_follow_q;
      end
      CS_DONE: begin
        cmd_o.fin  = st_i.out_free;
        cmd_o.last = 1'b1;
        if (end_blk_q) cmd_o.end_st = st_i.blk_crc_ok ? ST_OK : ST_BLOCK_CRC;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q         <= CS_WAIT;
      ph_q         <= PH_IDLE;
      end_st_q     <= ST_OK;
      end_blk_q    <= 1'b0;
      end_follow_q <= 1'b0;
    end else begin
      cs_q         <= cs_d;
      ph_q         <= ph_d;
      end_st_q     <= end_st_d;
      end_blk_q    <= end_blk_d;
      end_follow_q <= end_follow_d;
    end
  end

endmodule

### design/frr_dp.sv
// ----------------------------------------------------------------------------
// frr_dp: reply receiver datapath
// Item latch, frame store, header fields, CRC, counters and output register.
// ----------------------------------------------------------------------------
module frr_dp #(
  parameter int unsigned REPLY_CAP      = 65536,
  parameter int unsigned MAX_FRAMES     = 373,
  parameter int unsigned STALE_SKIP_MAX = 16384
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  frr_pkg::in_item_t in_data_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output frr_pkg::out_item_t out_data_o,
  input  logic              cfg_valid_i,
  input  logic [7:0]        cfg_data_i,
  input  frr_pkg::cmd_t     cmd_i,
  output frr_pkg::stat_t    st_o
);
  import frr_pkg::*;

  localparam logic [25:0] CapW   = 26'(REPLY_CAP);
  localparam logic [16:0] SkipW  = 17'(STALE_SKIP_MAX);
  localparam logic [9:0]  FrmMax = 10'(MAX_FRAMES);

  in_item_t    it_q;
  logic [31:0] expected_q, crc_q, crc_d, block_crc_q;
  logic [5:0]  idx_q;
  logic [23:0] rem_q;
  logic [24:0] used_q;
  logic [7:0]  stale_q, max_stale_q;
  logic [8:0]  frame_cnt_q;
  logic [7:0]  hdr_q [HdrBytes];
  logic [7:0]  frame_mem [64];
  logic [7:0]  rd_data_q;
  logic [5:0]  addr_q, addr_d, ei_q, n_q, n_w;
  logic        out_valid_q;
  out_item_t   out_q;
  logic        push;

  logic [15:0] flags_w, plen_w;
  logic [31:0] seq_w, csum_w, bcrc_w;

  assign flags_w = {hdr_q[7], hdr_q[6]};
  assign seq_w   = {hdr_q[11], hdr_q[10], hdr_q[9], hdr_q[8]};
  assign plen_w  = {hdr_q[13], hdr_q[12]};
  assign csum_w  = {hdr_q[19], hdr_q[18], hdr_q[17], hdr_q[16]};
  assign bcrc_w  = {hdr_q[23], hdr_q[22], hdr_q[21], hdr_q[20]};
  assign n_w     = (plen_w > 16'(PayloadMax)) ? PayloadMax : plen_w[5:0];

  always_comb begin
    st_o              = '0;
    st_o.accept       = in_valid_i && cmd_i.take;
    st_o.it_begin     = (it_q.req_type == ReqBegin);
    st_o.raw_zero     = (it_q.raw_length == 24'd0);
    st_o.raw_over     = {2'b00, it_q.raw_length} > CapW;
    st_o.rem_one      = (rem_q == 24'd1);
    st_o.idx_last     = (idx_q == 6'd63);
    st_o.hdr_bad      = (hdr_q[0] != MagicB0) || (hdr_q[1] != MagicB1) ||
                        (hdr_q[2] != MagicB2) || (hdr_q[3] != MagicB3) ||
                        (hdr_q[4] != FrameVer);
    st_o.crc_bad      = (~crc_q != csum_w);
    st_o.stale        = (seq_w != expected_q);
    st_o.flag_blk     = flags_w[1];
    st_o.flag_chain   = flags_w[0];
    st_o.plen_gt_skip = {1'b0, plen_w} > SkipW;
    st_o.plen_zero    = (plen_w == 16'd0);
    st_o.plen_ge_cap  = {10'd0, plen_w} >= CapW;
    st_o.cap_ok       = ({1'b0, used_q} + {20'd0, n_w}) < CapW;
    st_o.n_zero       = (n_w == 6'd0);
    st_o.frame_lim    = ({1'b0, frame_cnt_q} + 10'd1) >= FrmMax;
    st_o.stale_at_max = (stale_q >= max_stale_q);
    st_o.blk_crc_ok   = (~crc_q == block_crc_q);
    st_o.emit_last    = (ei_q == n_q - 6'd1);
    st_o.out_free     = !out_valid_q || !out_stall_i;
  end

  always_comb begin
    crc_d = crc_q;
    if (cmd_i.begin_req || cmd_i.chk || cmd_i.blk_start) begin
      crc_d = CrcInit;
    end else if (cmd_i.blk_b) begin
      crc_d = crc_byte(crc_q, it_q.rx_byte);
    end else if (cmd_i.frm_b) begin
      crc_d = crc_byte(crc_q, (idx_q[5:2] == 4'd4) ? 8'd0 : it_q.rx_byte);
    end
  end

  assign addr_d = cmd_i.chk ? PayloadOff : (cmd_i.emit ? addr_q + 6'd1 : addr_q);
  assign push   = cmd_i.raw_b || cmd_i.blk_b || cmd_i.emit || cmd_i.fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_q  <= '0;
      crc_q       <= CrcInit;
      block_crc_q <= '0;
      idx_q       <= '0;
      rem_q       <= '0;
      used_q      <= '0;
      stale_q     <= '0;
      frame_cnt_q <= '0;
      max_stale_q <= StaleReset;
      addr_q      <= '0;
      ei_q        <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      addr_q <= addr_d;
      if (cfg_valid_i) max_stale_q <= cfg_data_i;
      if (cmd_i.begin_req) begin
        expected_q  <= it_q.sequence_req;
        idx_q       <= '0;
        used_q      <= '0;
        stale_q     <= '0;
        frame_cnt_q <= '0;
        rem_q       <= it_q.raw_length;
        block_crc_q <= '0;
      end
      if (cmd_i.raw_b || cmd_i.blk_b) begin
        used_q <= used_q + 25'd1;
        rem_q  <= rem_q - 24'd1;
      end
      if (cmd_i.skip_b) rem_q <= rem_q - 24'd1;
      if (cmd_i.frm_b) idx_q <= idx_q + 6'd1;
      if (cmd_i.load_rem) rem_q <= {8'd0, plen_w};
      if (cmd_i.blk_start) begin
        block_crc_q <= bcrc_w;
        used_q      <= '0;
      end
      if (cmd_i.add_used) used_q <= used_q + {19'd0, n_w};
      if (cmd_i.frame_inc) frame_cnt_q <= frame_cnt_q + 9'd1;
      if (cmd_i.stale_inc) stale_q <= stale_q + 8'd1;
      if (cmd_i.chk) begin
        ei_q <= '0;
        n_q  <= n_w;
      end else if (cmd_i.emit) begin
        ei_q <= ei_q + 6'd1;
      end
      if (push) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers and frame store
  always_ff @(posedge clk_i) begin
    if (st_o.accept) it_q <= in_data_i;
    if (cmd_i.frm_b) begin
      frame_mem[idx_q] <= it_q.rx_byte;
      if (idx_q < 6'(HdrBytes)) hdr_q[idx_q[4:0]] <= it_q.rx_byte;
    end
    rd_data_q <= frame_mem[addr_d];
    if (push) begin
      out_q.kind         <= cmd_i.fin ? KindEnd : KindData;
      out_q.reply_byte   <= cmd_i.fin ? 8'd0 : (cmd_i.emit ? rd_data_q : it_q.rx_byte);
      out_q.unchecked    <= cmd_i.blk_b;
      out_q.status       <= cmd_i.fin ? cmd_i.end_st : ST_OK;
      out_q.reply_length <= (cmd_i.fin && cmd_i.end_st == ST_OK) ? used_q : 25'd0;
      out_q.last         <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/framed_reply_receiver.sv
// ----------------------------------------------------------------------------
// framed_reply_receiver: receiver for the reply to one request
// Raw pass-through or 64-byte frame collection with header, CRC-32, sequence
// and bulk block checks; emits data beats and one end beat with a status.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | beat
//  --------+-----------+-----------------------+------------------------------
//  in      | input     | in_valid_i/in_stall_o | begin request or one rx byte
//  out     | output    | out_valid_o/out_stall_i | reply byte or end status
//  cfg     | input     | cfg_valid_i/cfg_ready_o | max_stale_frames value
//
//  Flow: a beat is latched in CS_WAIT and processed in CS_STEP, so a new
//  item is taken only after the last one is through. The 64th byte of a
//  frame adds a check, an emit per payload byte (up to 44) and any end beat.
//  Reset: async active low; idle, max_stale_frames = 32; frame store unset.
//  Stalls: out_stall_i holds a result in the output register; processing
//  waits only when a new result is due and the register is still held.
//
module framed_reply_receiver #(
  parameter int unsigned REPLY_CAP      = 65536,
  parameter int unsigned MAX_FRAMES     = 373,
  parameter int unsigned STALE_SKIP_MAX = 16384
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  frr_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output frr_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i
);
  import frr_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // register write always lands at once
  assign cfg_ready_o = 1'b1;
  // input is taken only while the controller waits for an item
  assign in_stall_o  = !cmd.take;

  frr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  frr_dp #(
    .REPLY_CAP      (REPLY_CAP),
    .MAX_FRAMES     (MAX_FRAMES),
    .STALE_SKIP_MAX (STALE_SKIP_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .st_o        (st)
  );

`ifndef SYNTHESIS
  // one item at a time: an accepted beat is processed before the next
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous item in flight");

  a_data_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KindData |-> out_data_o.status == ST_OK)
    else $error("data beat with nonzero status");

  a_err_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KindEnd && out_data_o.status != ST_OK
    |-> out_data_o.reply_length == 25'd0)
    else $error("error end with nonzero length");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KindEnd |-> out_data_o.last)
    else $error("end beat not marked last");
`endif

endmodule
